/* rtl/core/unsigned_to_decimal_ascii_assert.svh */
// Assertion macros used by the converter top level.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/uda_pkg.sv */
// Package with widths, the decimal threshold table and controller types.
package uda_pkg;

  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 6;
  localparam int DIGIT_W  = 4;
  localparam int NUM_POS  = 10;
  localparam int POS_W    = 4;
  localparam int THR_W    = 34;
  localparam int NUM_THR  = 9;

  localparam logic [POS_W-1:0]  POS_TOP    = POS_W'(NUM_POS - 1);
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // One row holds d * 10^pos for d = 1 to 9.
  typedef logic [NUM_THR-1:0][THR_W-1:0] thr_row_t;
  typedef thr_row_t [NUM_POS-1:0]        thr_tab_t;

  function automatic thr_tab_t build_thr();
    thr_tab_t         tab;
    logic [THR_W-1:0] pw;
    pw = THR_W'(1);
    for (int p = 0; p < NUM_POS; p++) begin
      for (int d = 0; d < NUM_THR; d++) begin
        tab[p][d] = pw * THR_W'(d + 1);
      end
      pw = pw * THR_W'(10);
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr();

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_want;
    logic pos_zero;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/core/uda_value_if.sv */
// Input channel interface carrying one unsigned value per transaction.
interface uda_value_if
  import uda_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/core/uda_digit_if.sv */
// Output channel interface carrying one ASCII digit per transaction.
interface uda_digit_if
  import uda_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* rtl/core/unsigned_to_decimal_ascii.sv */
// Top level of the unsigned binary to decimal ASCII converter.
//
// The block takes one unsigned 32-bit value per transaction on in_i and
// returns its decimal text on out_o, one ASCII digit per transaction, most
// significant digit first and without leading zeros. Zero gives a single
// '0'. The final digit of each number carries last_digit.
// After a value is accepted, the controller walks the ten decimal positions
// from 10^9 down to 10^0, one position per cycle unless a digit waits for
// room in the output register, comparing the remainder against a constant
// table of multiples of the power of ten. Leading zero positions are skipped
// without output; a ten-digit number writes its first digit at the first step.
// A new value is taken only after the units step has ended the last conversion.
// in_i.ready is high whenever no conversion is running, even while the last
// digit of the previous number still waits in the output register.
// When the receiver stalls, the walk holds at the next digit to be shown until
// the output register frees; nothing is dropped.
// Reset (rst_ni, asynchronous, active low) returns the controller to idle and
// empties the output register; no state is kept from one number to the next.
module unsigned_to_decimal_ascii
  import uda_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  uda_value_if.sink   in_i,
  uda_digit_if.source out_o
);

`include "unsigned_to_decimal_ascii_assert.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    dp_emit;
  logic    units_step;

  // The controller owns the input handshake and decides when to step.
  uda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the remainder and drives the output channel.
  uda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.digit_char),
    .out_last_o  (out_o.last_digit)
  );

  // A step that writes a digit, and the step that handles the units position.
  assign dp_emit    = cmd.step && sts.emit_want;
  assign units_step = cmd.step && sts.pos_zero;

  // A digit is only written when the output register can take it.
  `UDA_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, dp_emit, sts.out_free, "digit overwritten")
  // Loading and stepping never happen in the same cycle.
  `UDA_ASSERT_NOW(a_load_xor_step, clk_i, rst_ni, cmd.load, !cmd.step, "load and step together")
  // A new value closes the input until its conversion ends.
  `UDA_ASSERT_NXT(a_busy_after_load, clk_i, rst_ni, cmd.load, !in_i.ready, "input open early")
  // The step at the units position ends the conversion.
  `UDA_ASSERT_NXT(a_idle_after_units, clk_i, rst_ni, units_step, in_i.ready, "not idle")

endmodule

/* rtl/core/uda_ctrl.sv */
// Controller state machine that sequences one conversion at a time.
module uda_ctrl
  import uda_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        // A skipped leading zero needs no room in the output register.
        if (!sts_i.emit_want || sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.pos_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/uda_datapath.sv */
// Datapath: remainder register, digit extraction and the output register.
module uda_datapath
  import uda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VALUE_W-1:0] value_i,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  out_char_o,
  output logic               out_last_o
);

  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               started_q, started_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  thr_row_t           row;
  logic [DIGIT_W-1:0] digit;
  logic [THR_W-1:0]   sub_val;
  logic               emit;

  // Digit at the current position: the largest d with d * 10^pos <= remainder.
  always_comb begin
    row     = THR_TAB[pos_q];
    digit   = '0;
    sub_val = '0;
    for (int d = 0; d < NUM_THR; d++) begin
      if ({{(THR_W - VALUE_W){1'b0}}, rem_q} >= row[d]) begin
        digit   = DIGIT_W'(d + 1);
        sub_val = row[d];
      end
    end
  end

  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.emit_want = started_q || (digit != '0) || (pos_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign emit            = cmd_i.step && sts_o.emit_want;

  always_comb begin
    rem_d       = rem_q;
    pos_d       = pos_q;
    started_d   = started_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      rem_d     = value_i;
      pos_d     = POS_TOP;
      started_d = 1'b0;
    end else if (cmd_i.step) begin
      rem_d = rem_q - sub_val[VALUE_W-1:0];
      pos_d = pos_q - POS_W'(1);
    end
    if (emit) begin
      started_d   = 1'b1;
      out_char_d  = ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digit};
      out_last_d  = sts_o.pos_zero;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    pos_q      <= pos_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule
